### sv/cqe_pkg.sv
// Package for the circular queue engine: sizes, operation and status codes,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
package cqe_pkg;

   localparam int DEPTH = 16;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int MODE_W = 3;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ   = 3'd0,
      MODE_DEQ   = 3'd1,
      MODE_PEEK  = 3'd2,
      MODE_TRAV  = 3'd3,
      MODE_EMPTY = 3'd4,
      MODE_SIZE  = 3'd5
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;
      logic load_rd;
      logic next;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_read;
      logic has_result;
      logic out_last;
   } sts_type;

endpackage

### sv/circular_queue_engine_unit.sv
// Circular queue of signed 32-bit values, 16 slots, of which the csr register sets how
// many are in use; writing it empties the queue. One transaction at a time: enqueue,
// dequeue, empty check and size take the request and present their single result in
// the next cycle, and a new request is taken in the cycle after the result leaves.
// Peek and traverse read the slot memory through its registered read port: each result
// passes through the read, load and handoff steps, peek returns one element and rear,
// and traverse repeats the steps for each stored value. On an empty queue both skip the
// read and give a single result. Results leave from an output register; the final result
// of a request carries rsp_last.
// Depends on cqe_pkg, cqe_ctrl and cqe_dpath.
module circular_queue_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic        [cqe_pkg::MODE_W-1:0] req_mode,
   input  logic signed [cqe_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic        [cqe_pkg::STAT_W-1:0] rsp_status,
   output logic signed [cqe_pkg::DATA_W-1:0] rsp_element,
   output logic signed [cqe_pkg::DATA_W-1:0] rsp_rear_element,
   output logic        [cqe_pkg::OCC_W-1:0]  rsp_occupancy,
   output logic                              rsp_empty_flag,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic        [cqe_pkg::CAP_W-1:0]  csr_wr_data
);

   cqe_pkg::cmd_type cmd;
   cqe_pkg::sts_type sts;

   cqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cqe_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_status       (rsp_status),
      .rsp_element      (rsp_element),
      .rsp_rear_element (rsp_rear_element),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_empty_flag   (rsp_empty_flag),
      .rsp_last         (rsp_last)
   );

`ifndef ASSERT_OFF
   // No request is taken while a result is still on offer.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request channel open while a result is pending");

   // Once the final result of a transaction leaves, the block is ready again.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall)
      else $error("block not ready after final result");

   // The reported occupancy never exceeds the slot count.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_occupancy) <= 32'(cqe_pkg::DEPTH)))
      else $error("occupancy beyond queue depth");

   // Empty flag and occupancy agree on every result.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_flag == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");
`endif

endmodule

### sv/cqe_ctrl.sv
// Controller state machine of the circular queue engine.
// Depends on cqe_pkg for the state encoding and the command and status bundles.
module cqe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  cqe_pkg::sts_type sts,
   output cqe_pkg::cmd_type cmd
);

   cqe_pkg::state_type state_ff;
   cqe_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cqe_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cqe_pkg::S_IDLE: begin
            if (req_valid) begin
               priority if (sts.need_read) begin
                  state_in = cqe_pkg::S_READ;
               end else if (sts.has_result) begin
                  state_in = cqe_pkg::S_OUT;
               end else begin
                  state_in = cqe_pkg::S_IDLE;
               end
            end
         end
         cqe_pkg::S_READ: begin
            state_in = cqe_pkg::S_LOAD;
         end
         cqe_pkg::S_LOAD: begin
            state_in = cqe_pkg::S_OUT;
         end
         cqe_pkg::S_OUT: begin
            if (!rsp_stall) begin
               state_in = sts.out_last ? cqe_pkg::S_IDLE : cqe_pkg::S_READ;
            end
         end
         default: begin
            state_in = cqe_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != cqe_pkg::S_IDLE);
      rsp_valid   = (state_ff == cqe_pkg::S_OUT);
      cmd.exec    = (state_ff == cqe_pkg::S_IDLE) && req_valid;
      cmd.load_rd = (state_ff == cqe_pkg::S_LOAD);
      cmd.next    = (state_ff == cqe_pkg::S_OUT) && !rsp_stall && !sts.out_last;
   end

endmodule

### sv/cqe_dpath.sv
// Datapath of the circular queue engine: slot memory, pointers, count, walk cursor
// and the result register. Depends on cqe_pkg.
module cqe_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cqe_pkg::cmd_type                     cmd,
   output cqe_pkg::sts_type                     sts,
   input  logic        [cqe_pkg::MODE_W-1:0]    req_mode,
   input  logic signed [cqe_pkg::DATA_W-1:0]    req_value,
   input  logic                                 csr_wr_en,
   input  logic        [cqe_pkg::CAP_W-1:0]     csr_wr_data,
   output logic        [cqe_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [cqe_pkg::DATA_W-1:0]    rsp_element,
   output logic signed [cqe_pkg::DATA_W-1:0]    rsp_rear_element,
   output logic        [cqe_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic                                 rsp_empty_flag,
   output logic                                 rsp_last
);

   logic signed [cqe_pkg::DATA_W-1:0] mem_ff [cqe_pkg::DEPTH];

   logic [cqe_pkg::CAP_W-1:0] cap_ff;
   logic [cqe_pkg::PTR_W-1:0] head_ff, head_in;
   logic [cqe_pkg::PTR_W-1:0] tail_ff, tail_in;
   logic [cqe_pkg::CNT_W-1:0] count_ff, count_in;
   logic [cqe_pkg::PTR_W-1:0] cursor_ff;
   logic [cqe_pkg::CNT_W-1:0] remain_ff;
   logic                      peek_ff;

   logic signed [cqe_pkg::DATA_W-1:0] rd_front_ff;
   logic signed [cqe_pkg::DATA_W-1:0] rd_rear_ff;

   cqe_pkg::status_type               out_status_ff;
   logic signed [cqe_pkg::DATA_W-1:0] out_element_ff;
   logic signed [cqe_pkg::DATA_W-1:0] out_rear_ff;
   logic        [cqe_pkg::OCC_W-1:0]  out_occ_ff;
   logic                              out_empty_ff;
   logic                              out_last_ff;

   logic [cqe_pkg::CNT_W-1:0] cap_act;
   logic [cqe_pkg::PTR_W-1:0] rear_idx;
   logic                      full;
   logic                      empty;
   logic                      wr_en;
   logic                      need_read;
   logic                      has_result;
   cqe_pkg::status_type       res_status;

   // Pointer step with wrap at the capacity in use.
   function automatic logic [cqe_pkg::PTR_W-1:0] advance(
      input logic [cqe_pkg::PTR_W-1:0] idx,
      input logic [cqe_pkg::CNT_W-1:0] cap
   );
      logic [cqe_pkg::CNT_W-1:0] nx;
      nx = cqe_pkg::CNT_W'(idx) + cqe_pkg::CNT_W'(1);
      return (nx >= cap) ? '0 : cqe_pkg::PTR_W'(nx);
   endfunction

   // A capacity of zero acts as one slot, and one beyond the memory as the full memory.
   always_comb begin
      priority if (cap_ff == '0) begin
         cap_act = cqe_pkg::CNT_W'(1);
      end else if (32'(cap_ff) > 32'(cqe_pkg::DEPTH)) begin
         cap_act = cqe_pkg::CNT_W'(cqe_pkg::DEPTH);
      end else begin
         cap_act = cqe_pkg::CNT_W'(cap_ff);
      end
   end

   assign full  = (count_ff >= cap_act);
   assign empty = (count_ff == '0);

   // The tail always sits count slots past the head, so the rear is one slot behind it.
   assign rear_idx = (tail_ff == '0) ? cqe_pkg::PTR_W'(cap_act - cqe_pkg::CNT_W'(1))
                                     : tail_ff - cqe_pkg::PTR_W'(1);

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      need_read  = 1'b0;
      has_result = 1'b1;
      res_status = cqe_pkg::ST_OK;
      unique case (req_mode)
         cqe_pkg::MODE_ENQ: begin
            if (full) begin
               res_status = cqe_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               tail_in  = advance(tail_ff, cap_act);
               count_in = count_ff + cqe_pkg::CNT_W'(1);
            end
         end
         cqe_pkg::MODE_DEQ: begin
            if (empty) begin
               res_status = cqe_pkg::ST_EMPTY;
            end else begin
               head_in  = advance(head_ff, cap_act);
               count_in = count_ff - cqe_pkg::CNT_W'(1);
            end
         end
         cqe_pkg::MODE_PEEK, cqe_pkg::MODE_TRAV: begin
            if (empty) begin
               res_status = cqe_pkg::ST_EMPTY;
            end else begin
               need_read = 1'b1;
            end
         end
         cqe_pkg::MODE_EMPTY, cqe_pkg::MODE_SIZE: begin
            res_status = empty ? cqe_pkg::ST_EMPTY : cqe_pkg::ST_OK;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= cqe_pkg::CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (csr_wr_en) begin
         cap_ff   <= csr_wr_data;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cursor_ff <= head_ff;
         remain_ff <= count_ff;
         peek_ff   <= (req_mode == cqe_pkg::MODE_PEEK);
      end else if (cmd.next) begin
         cursor_ff <= advance(cursor_ff, cap_act);
         remain_ff <= remain_ff - cqe_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem_ff[tail_ff] <= req_value;
      end
      rd_front_ff <= mem_ff[cursor_ff];
      rd_rear_ff  <= mem_ff[rear_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         out_status_ff  <= res_status;
         out_element_ff <= '0;
         out_rear_ff    <= '0;
         out_occ_ff     <= cqe_pkg::OCC_W'(count_in);
         out_empty_ff   <= (count_in == '0);
         out_last_ff    <= 1'b1;
      end else if (cmd.load_rd) begin
         out_status_ff  <= cqe_pkg::ST_OK;
         out_element_ff <= rd_front_ff;
         out_rear_ff    <= peek_ff ? rd_rear_ff : '0;
         out_occ_ff     <= cqe_pkg::OCC_W'(count_ff);
         out_empty_ff   <= 1'b0;
         out_last_ff    <= peek_ff || (remain_ff == cqe_pkg::CNT_W'(1));
      end
   end

   always_comb begin
      sts.need_read  = need_read;
      sts.has_result = has_result;
      sts.out_last   = out_last_ff;
   end

   assign rsp_status       = out_status_ff;
   assign rsp_element      = out_element_ff;
   assign rsp_rear_element = out_rear_ff;
   assign rsp_occupancy    = out_occ_ff;
   assign rsp_empty_flag   = out_empty_ff;
   assign rsp_last         = out_last_ff;

endmodule

### test/circular_queue_engine_unit_test.sv
// Self-checking testbench for circular_queue_engine_unit: a directed table followed by
// random phases under varied capacities, with a predictor of the queue for every response.
// Depends on cqe_pkg and the circular_queue_engine_unit RTL.
module circular_queue_engine_unit_test;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 24;
   localparam logic [cqe_pkg::MODE_W-1:0] MODE_UNUSED_A = 3'd6;
   localparam logic [cqe_pkg::MODE_W-1:0] MODE_UNUSED_B = 3'd7;

   typedef struct {
      logic        [cqe_pkg::STAT_W-1:0] status;
      logic signed [cqe_pkg::DATA_W-1:0] element;
      logic signed [cqe_pkg::DATA_W-1:0] rear_element;
      logic        [cqe_pkg::OCC_W-1:0]  occupancy;
      logic                              empty_flag;
      logic                              last;
   } queue_result_type;

   typedef struct {
      bit                                is_cfg;
      logic        [cqe_pkg::CAP_W-1:0]  cap;
      logic        [cqe_pkg::MODE_W-1:0] mode;
      logic signed [cqe_pkg::DATA_W-1:0] value;
      bit                                known;
      queue_result_type                  want;
   } plan_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic        [cqe_pkg::MODE_W-1:0] req_mode;
   logic signed [cqe_pkg::DATA_W-1:0] req_value;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic        [cqe_pkg::STAT_W-1:0] rsp_status;
   logic signed [cqe_pkg::DATA_W-1:0] rsp_element;
   logic signed [cqe_pkg::DATA_W-1:0] rsp_rear_element;
   logic        [cqe_pkg::OCC_W-1:0]  rsp_occupancy;
   logic                              rsp_empty_flag;
   logic                              rsp_last;
   logic                              csr_wr_en;
   logic        [cqe_pkg::CAP_W-1:0]  csr_wr_data;

   // Predicted queue contents and pointers.
   logic signed [cqe_pkg::DATA_W-1:0] slot_mem [cqe_pkg::DEPTH];
   logic        [cqe_pkg::PTR_W-1:0]  front_ptr;
   logic        [cqe_pkg::PTR_W-1:0]  back_ptr;
   logic        [cqe_pkg::CNT_W-1:0]  fill;
   logic        [cqe_pkg::CAP_W-1:0]  cap_reg;

   queue_result_type pending[$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int capacity_writes = 0;
   int cycle_count = 0;

   circular_queue_engine_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_element      (rsp_element),
      .rsp_rear_element (rsp_rear_element),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_empty_flag   (rsp_empty_flag),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A register value of zero behaves as one slot, and anything above DEPTH as DEPTH.
   function automatic logic [cqe_pkg::CNT_W-1:0] active_slots();
      if (cap_reg == '0) return cqe_pkg::CNT_W'(1);
      if (int'(cap_reg) > cqe_pkg::DEPTH) return cqe_pkg::CNT_W'(cqe_pkg::DEPTH);
      return cqe_pkg::CNT_W'(cap_reg);
   endfunction

   function automatic logic [cqe_pkg::PTR_W-1:0] step_ptr(
      input logic [cqe_pkg::PTR_W-1:0] ptr,
      input logic [cqe_pkg::CNT_W-1:0] cap
   );
      logic [cqe_pkg::CNT_W-1:0] nx;
      nx = cqe_pkg::CNT_W'(ptr) + cqe_pkg::CNT_W'(1);
      return (nx >= cap) ? '0 : cqe_pkg::PTR_W'(nx);
   endfunction

   function automatic void set_capacity(input logic [cqe_pkg::CAP_W-1:0] cap);
      cap_reg   = cap;
      front_ptr = '0;
      back_ptr  = '0;
      fill      = '0;
   endfunction

   // Applies one request to the predicted queue; when record is set, the
   // responses it causes are appended to the pending list.
   task automatic model_queue_op(input logic [cqe_pkg::MODE_W-1:0] mode,
                                 input logic signed [cqe_pkg::DATA_W-1:0] value,
                                 input bit record);
      logic [cqe_pkg::CNT_W-1:0] cap;
      logic [cqe_pkg::PTR_W-1:0] idx;
      logic [cqe_pkg::PTR_W-1:0] rear;
      queue_result_type r;
      cap            = active_slots();
      r.status       = cqe_pkg::ST_OK;
      r.element      = '0;
      r.rear_element = '0;
      r.last         = 1'b1;
      case (mode)
         cqe_pkg::MODE_ENQ: begin
            if (fill >= cap) begin
               r.status = cqe_pkg::ST_FULL;
            end else begin
               slot_mem[back_ptr] = value;
               back_ptr = step_ptr(back_ptr, cap);
               fill = fill + 1'b1;
            end
         end
         cqe_pkg::MODE_DEQ: begin
            if (fill == '0) begin
               r.status = cqe_pkg::ST_EMPTY;
            end else begin
               front_ptr = step_ptr(front_ptr, cap);
               fill = fill - 1'b1;
            end
         end
         cqe_pkg::MODE_PEEK: begin
            if (fill == '0) begin
               r.status = cqe_pkg::ST_EMPTY;
            end else begin
               rear = cqe_pkg::PTR_W'((cqe_pkg::CNT_W'(front_ptr) + fill
                                       - cqe_pkg::CNT_W'(1)) % cap);
               r.element      = slot_mem[front_ptr];
               r.rear_element = slot_mem[rear];
            end
         end
         cqe_pkg::MODE_TRAV: begin
            if (fill == '0) begin
               r.status = cqe_pkg::ST_EMPTY;
            end else begin
               idx = front_ptr;
               for (int i = 0; i < int'(fill); i++) begin
                  r.element    = slot_mem[idx];
                  r.last       = (i + 1 == int'(fill));
                  r.occupancy  = cqe_pkg::OCC_W'(fill);
                  r.empty_flag = 1'b0;
                  if (record) pending.push_back(r);
                  idx = step_ptr(idx, cap);
               end
               return;
            end
         end
         cqe_pkg::MODE_EMPTY, cqe_pkg::MODE_SIZE: begin
            if (fill == '0) r.status = cqe_pkg::ST_EMPTY;
         end
         default: return;
      endcase
      r.occupancy  = cqe_pkg::OCC_W'(fill);
      r.empty_flag = (fill == '0);
      if (record) pending.push_back(r);
   endtask

   task automatic send_item(input logic [cqe_pkg::MODE_W-1:0] mode,
                            input logic signed [cqe_pkg::DATA_W-1:0] value,
                            input bit known, input queue_result_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      model_queue_op(mode, value, !known);
      if (known) pending.push_back(want);
   endtask

   // The register may only change while the block is idle, so every pending
   // response is collected first, then a short pause covers ignored requests.
   task automatic write_capacity(input logic [cqe_pkg::CAP_W-1:0] cap);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      set_capacity(cap);
      capacity_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [cqe_pkg::DATA_W-1:0] want,
                              input logic [cqe_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   function automatic plan_row_type row_op(input logic [cqe_pkg::MODE_W-1:0] mode,
                                           input logic signed [cqe_pkg::DATA_W-1:0] value);
      plan_row_type row;
      row = '{default: '0};
      row.mode  = mode;
      row.value = value;
      return row;
   endfunction

   function automatic plan_row_type row_known(
      input logic        [cqe_pkg::MODE_W-1:0] mode,
      input logic signed [cqe_pkg::DATA_W-1:0] value,
      input logic        [cqe_pkg::STAT_W-1:0] status,
      input logic signed [cqe_pkg::DATA_W-1:0] element,
      input logic signed [cqe_pkg::DATA_W-1:0] rear,
      input logic        [cqe_pkg::OCC_W-1:0]  occupancy
   );
      plan_row_type row;
      row = row_op(mode, value);
      row.known             = 1'b1;
      row.want.status       = status;
      row.want.element      = element;
      row.want.rear_element = rear;
      row.want.occupancy    = occupancy;
      row.want.empty_flag   = (occupancy == '0);
      row.want.last         = 1'b1;
      return row;
   endfunction

   function automatic plan_row_type row_cfg(input logic [cqe_pkg::CAP_W-1:0] cap);
      plan_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.cap    = cap;
      return row;
   endfunction

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (pending.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual status %0d element %0h",
                     $time, rsp_status, rsp_element);
         end else begin
            want = pending.pop_front();
            check_field("status", cqe_pkg::DATA_W'(want.status),
                        cqe_pkg::DATA_W'(rsp_status));
            check_field("element", want.element, rsp_element);
            check_field("rear_element", want.rear_element, rsp_rear_element);
            check_field("occupancy", cqe_pkg::DATA_W'(want.occupancy),
                        cqe_pkg::DATA_W'(rsp_occupancy));
            check_field("empty_flag", cqe_pkg::DATA_W'(want.empty_flag),
                        cqe_pkg::DATA_W'(rsp_empty_flag));
            check_field("last", cqe_pkg::DATA_W'(want.last), cqe_pkg::DATA_W'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("circular_queue_engine_unit verification failed");
         $finish;
      end
   end

   initial begin
      plan_row_type plan[$];
      queue_result_type none;
      int roll;
      int enq_pct;
      logic        [cqe_pkg::CAP_W-1:0]  cap_pick;
      logic        [cqe_pkg::MODE_W-1:0] mode_pick;
      logic signed [cqe_pkg::DATA_W-1:0] value_pick;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = cqe_pkg::MODE_ENQ;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      none        = '{default: '0};
      set_capacity(cqe_pkg::CAP_RESET);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every operation on an empty queue, then the value extremes.
      plan.push_back(row_known(cqe_pkg::MODE_DEQ,   0, cqe_pkg::ST_EMPTY, 0, 0, 5'd0));
      plan.push_back(row_known(cqe_pkg::MODE_PEEK,  0, cqe_pkg::ST_EMPTY, 0, 0, 5'd0));
      plan.push_back(row_known(cqe_pkg::MODE_TRAV,  0, cqe_pkg::ST_EMPTY, 0, 0, 5'd0));
      plan.push_back(row_known(cqe_pkg::MODE_EMPTY, 0, cqe_pkg::ST_EMPTY, 0, 0, 5'd0));
      plan.push_back(row_known(cqe_pkg::MODE_SIZE,  0, cqe_pkg::ST_EMPTY, 0, 0, 5'd0));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 32'h7fffffff, cqe_pkg::ST_OK, 0, 0, 5'd1));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 32'h80000000, cqe_pkg::ST_OK, 0, 0, 5'd2));
      plan.push_back(row_known(cqe_pkg::MODE_PEEK, 0, cqe_pkg::ST_OK,
                               32'h7fffffff, 32'h80000000, 5'd2));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 0, cqe_pkg::ST_OK, 0, 0, 5'd3));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, -1, cqe_pkg::ST_OK, 0, 0, 5'd4));
      plan.push_back(row_op(cqe_pkg::MODE_TRAV, 0));
      plan.push_back(row_op(MODE_UNUSED_A, 32'h12345678));
      plan.push_back(row_op(MODE_UNUSED_B, -1));
      plan.push_back(row_known(cqe_pkg::MODE_EMPTY, 0, cqe_pkg::ST_OK, 0, 0, 5'd4));
      plan.push_back(row_known(cqe_pkg::MODE_SIZE, 0, cqe_pkg::ST_OK, 0, 0, 5'd4));
      plan.push_back(row_known(cqe_pkg::MODE_DEQ, 0, cqe_pkg::ST_OK, 0, 0, 5'd3));
      plan.push_back(row_op(cqe_pkg::MODE_PEEK, 0));
      // Two slots: tail wrap and overflow, then a traverse and peek across the wrap.
      plan.push_back(row_cfg(5'd2));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 5, cqe_pkg::ST_OK, 0, 0, 5'd1));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 6, cqe_pkg::ST_OK, 0, 0, 5'd2));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 7, cqe_pkg::ST_FULL, 0, 0, 5'd2));
      plan.push_back(row_known(cqe_pkg::MODE_DEQ, 0, cqe_pkg::ST_OK, 0, 0, 5'd1));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 8, cqe_pkg::ST_OK, 0, 0, 5'd2));
      plan.push_back(row_op(cqe_pkg::MODE_TRAV, 0));
      plan.push_back(row_op(cqe_pkg::MODE_PEEK, 0));
      // A capacity of zero holds one element.
      plan.push_back(row_cfg(5'd0));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 9, cqe_pkg::ST_OK, 0, 0, 5'd1));
      plan.push_back(row_known(cqe_pkg::MODE_ENQ, 10, cqe_pkg::ST_FULL, 0, 0, 5'd1));
      plan.push_back(row_op(cqe_pkg::MODE_TRAV, 0));

      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_capacity(plan[i].cap);
         else send_item(plan[i].mode, plan[i].value, plan[i].known, plan[i].want);
      end

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         // Enqueue-heavy phases reach the full condition at the largest capacity.
         case (phase)
            0: begin cap_pick = 5'd16; enq_pct = 75; end
            1: begin cap_pick = 5'd31; enq_pct = 50; end
            2: begin cap_pick = 5'd1;  enq_pct = 45; end
            3: begin cap_pick = cqe_pkg::CAP_W'($urandom_range(2, 15));  enq_pct = 55; end
            4: begin cap_pick = 5'd0;  enq_pct = 40; end
            5: begin cap_pick = cqe_pkg::CAP_W'($urandom_range(17, 30)); enq_pct = 70; end
            6: begin cap_pick = cqe_pkg::CAP_W'($urandom_range(2, 15));  enq_pct = 35; end
            default: begin cap_pick = 5'd16; enq_pct = 60; end
         endcase
         write_capacity(cap_pick);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < enq_pct) begin
               mode_pick = cqe_pkg::MODE_ENQ;
            end else begin
               roll = $urandom_range(0, 19);
               if (roll < 6) mode_pick = cqe_pkg::MODE_DEQ;
               else if (roll < 9) mode_pick = cqe_pkg::MODE_PEEK;
               else if (roll < 12) mode_pick = cqe_pkg::MODE_TRAV;
               else if (roll < 15) mode_pick = cqe_pkg::MODE_EMPTY;
               else if (roll < 18) mode_pick = cqe_pkg::MODE_SIZE;
               else mode_pick = $urandom_range(0, 1) ? MODE_UNUSED_A : MODE_UNUSED_B;
            end
            case ($urandom_range(0, 15))
               0: value_pick = 32'h7fffffff;
               1: value_pick = 32'h80000000;
               2: value_pick = 0;
               3: value_pick = -1;
               default: value_pick = $urandom;
            endcase
            send_item(mode_pick, value_pick, 1'b0, none);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d requests and %0d responses across %0d capacity writes,",
               requests_sent, responses_seen, capacity_writes);
      $display("with sender gaps and response stalls varied per phase; %0d mismatches.",
               error_count);
      if (error_count == 0) $display("circular_queue_engine_unit verification clean");
      else $display("circular_queue_engine_unit verification failed");
      $finish;
   end

endmodule
